// ===== design/vau_pkg.sv =====
// Package for the vector3 arithmetic unit: shared widths, command and error codes,
// the arccosine polynomial coefficients, the pipeline payload struct and the root step.
// No dependencies.
`timescale 1ns / 1ps

package vau_pkg;

  localparam int COORD_W   = 32;
  localparam int WIDE_W    = 2 * COORD_W;
  localparam int FRAC_BITS = 16;
  localparam int ANG_SHIFT = 30 - FRAC_BITS;

  localparam int FRONT_STAGES = 3;
  localparam int SQ_STEPS     = WIDE_W / 2;
  localparam int DIV_STEPS    = 30;
  localparam int POLY_STEPS   = 7;

  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_SUB     = 3'd1;
  localparam logic [2:0] CMD_DOT     = 3'd2;
  localparam logic [2:0] CMD_LEN     = 3'd3;
  localparam logic [2:0] CMD_ANGLE   = 3'd4;
  localparam logic [2:0] CMD_EQUAL   = 3'd5;
  localparam logic [2:0] CMD_LONGER  = 3'd6;
  localparam logic [2:0] CMD_SHORTER = 3'd7;

  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_ZERO = 2'd1;
  localparam logic [1:0] ERR_SAT  = 2'd2;

  // acos(x) = sqrt(1-x) * P(x), coefficients in Q30, constant term first
  localparam logic signed [32:0] ACOS_COEF [8] = '{
    33'sd1686629690, -33'sd230423709, 33'sd95540460, -33'sd53874249,
    33'sd33169905, -33'sd18348235, 33'sd7161955, -33'sd1355590
  };

  localparam logic signed [63:0] PI_Q30  = 64'sd3373259426;
  localparam logic [30:0]        Q30_ONE = 31'h4000_0000;

  typedef struct packed {
    logic [WIDE_W-1:0]  rad;
    logic [COORD_W:0]   rem;
    logic [COORD_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [2:0]          cmd;
    logic [COORD_W-1:0]  rx;
    logic [COORD_W-1:0]  ry;
    logic [COORD_W-1:0]  rz;
    logic [WIDE_W-1:0]   scalar;
    logic                cmp;
    logic [1:0]          err;
    logic                neg;
    logic                zero;
    logic                clamp;
    logic [WIDE_W-1:0]   mag;
    logic [WIDE_W-1:0]   den;
    logic [30:0]         x;
    logic signed [32:0]  p;
    sq_t                 sqa;
    sq_t                 sqb;
  } pl_t;

  // one digit of a restoring square root: two radicand bits in, one root bit out
  function automatic sq_t sqrt_step(sq_t s);
    logic [COORD_W+2:0] rem2;
    logic [COORD_W+2:0] trial;
    sq_t                o;
    rem2  = {s.rem, s.rad[WIDE_W-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    o.rad = {s.rad[WIDE_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      o.rem  = (COORD_W+1)'(rem2 - trial);
      o.root = {s.root[COORD_W-2:0], 1'b1};
    end else begin
      o.rem  = rem2[COORD_W:0];
      o.root = {s.root[COORD_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ===== design/vau_front.sv =====
// Front end: add/sub with saturation, the nine products, dot and squared-length sums,
// and the per-command results that need no root. Three register stages. Uses vau_pkg.
`timescale 1ns / 1ps

module vau_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [2:0]                          in_cmd,
  input  logic signed [vau_pkg::COORD_W-1:0]  in_a_x,
  input  logic signed [vau_pkg::COORD_W-1:0]  in_a_y,
  input  logic signed [vau_pkg::COORD_W-1:0]  in_a_z,
  input  logic signed [vau_pkg::COORD_W-1:0]  in_b_x,
  input  logic signed [vau_pkg::COORD_W-1:0]  in_b_y,
  input  logic signed [vau_pkg::COORD_W-1:0]  in_b_z,
  output logic                                out_v,
  output vau_pkg::pl_t                        out_d
);

  localparam int CW = vau_pkg::COORD_W;
  localparam int WW = vau_pkg::WIDE_W;

  // stage 1
  logic                 v1_r;
  logic [2:0]           cmd1_r, cmd1_nxt;
  logic [CW-1:0]        r1_r [3];
  logic [CW-1:0]        r1_nxt [3];
  logic                 sat1_r, sat1_nxt;
  logic                 eq1_r, eq1_nxt;
  logic signed [WW-1:0] prod1_r [3];
  logic signed [WW-1:0] prod1_nxt [3];
  logic [WW-1:0]        sqa1_r [3];
  logic [WW-1:0]        sqa1_nxt [3];
  logic [WW-1:0]        sqb1_r [3];
  logic [WW-1:0]        sqb1_nxt [3];

  // stage 2
  logic                 v2_r;
  logic [2:0]           cmd2_r;
  logic [CW-1:0]        r2_r [3];
  logic                 sat2_r;
  logic                 eq2_r;
  logic [WW-1:0]        pos2_r, pos2_nxt;
  logic [WW-1:0]        neg2_r, neg2_nxt;
  logic [WW-1:0]        sa2_r, sa2_nxt;
  logic [WW-1:0]        sb2_r, sb2_nxt;

  // stage 3
  logic                 v3_r;
  vau_pkg::pl_t         d3_r, d3_nxt;

  always_comb begin
    logic signed [CW-1:0] av [3];
    logic signed [CW-1:0] bv [3];
    logic signed [CW:0]   s;
    logic [CW-1:0]        max_c;
    av[0] = in_a_x; av[1] = in_a_y; av[2] = in_a_z;
    bv[0] = in_b_x; bv[1] = in_b_y; bv[2] = in_b_z;
    max_c = {1'b0, {(CW-1){1'b1}}};
    cmd1_nxt = in_cmd;
    sat1_nxt = 1'b0;
    eq1_nxt  = (av[0] == bv[0]) && (av[1] == bv[1]) && (av[2] == bv[2]);
    for (int i = 0; i < 3; i++) begin
      if (in_cmd == vau_pkg::CMD_SUB) begin
        s = {av[i][CW-1], av[i]} - {bv[i][CW-1], bv[i]};
      end else begin
        s = {av[i][CW-1], av[i]} + {bv[i][CW-1], bv[i]};
      end
      if (in_cmd != vau_pkg::CMD_ADD && in_cmd != vau_pkg::CMD_SUB) begin
        r1_nxt[i] = '0;
      end else if (s[CW] != s[CW-1]) begin
        r1_nxt[i] = s[CW] ? ~max_c : max_c;
        sat1_nxt  = 1'b1;
      end else begin
        r1_nxt[i] = s[CW-1:0];
      end
      prod1_nxt[i] = av[i] * bv[i];
      sqa1_nxt[i]  = WW'(av[i] * av[i]);
      sqb1_nxt[i]  = WW'(bv[i] * bv[i]);
    end
  end

  always_comb begin
    logic [WW-1:0] m;
    pos2_nxt = '0;
    neg2_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      m = prod1_r[i][WW-1] ? WW'(-prod1_r[i]) : WW'(prod1_r[i]);
      if (prod1_r[i][WW-1]) begin
        neg2_nxt = neg2_nxt + m;
      end else begin
        pos2_nxt = pos2_nxt + m;
      end
    end
    sa2_nxt = sqa1_r[0] + sqa1_r[1] + sqa1_r[2];
    sb2_nxt = sqb1_r[0] + sqb1_r[1] + sqb1_r[2];
  end

  always_comb begin
    logic          negv;
    logic [WW-1:0] mag;
    negv = neg2_r > pos2_r;
    mag  = negv ? neg2_r - pos2_r : pos2_r - neg2_r;
    d3_nxt         = '0;
    d3_nxt.cmd     = cmd2_r;
    d3_nxt.rx      = r2_r[0];
    d3_nxt.ry      = r2_r[1];
    d3_nxt.rz      = r2_r[2];
    d3_nxt.neg     = negv;
    d3_nxt.mag     = mag;
    d3_nxt.zero    = (sa2_r == '0) || (sb2_r == '0);
    d3_nxt.sqa.rad = sa2_r;
    d3_nxt.sqb.rad = sb2_r;
    d3_nxt.p       = vau_pkg::ACOS_COEF[7];
    d3_nxt.err     = vau_pkg::ERR_OK;
    case (cmd2_r)
      vau_pkg::CMD_ADD, vau_pkg::CMD_SUB: begin
        if (sat2_r) d3_nxt.err = vau_pkg::ERR_SAT;
      end
      vau_pkg::CMD_DOT: begin
        if (!negv && mag[WW-1]) begin
          d3_nxt.scalar = {1'b0, {(WW-1){1'b1}}};
          d3_nxt.err    = vau_pkg::ERR_SAT;
        end else if (negv && mag > {1'b1, {(WW-1){1'b0}}}) begin
          d3_nxt.scalar = {1'b1, {(WW-1){1'b0}}};
          d3_nxt.err    = vau_pkg::ERR_SAT;
        end else begin
          d3_nxt.scalar = negv ? WW'(-mag) : mag;
        end
      end
      vau_pkg::CMD_ANGLE: begin
        if (d3_nxt.zero) d3_nxt.err = vau_pkg::ERR_ZERO;
      end
      vau_pkg::CMD_EQUAL:   d3_nxt.cmp = eq2_r;
      vau_pkg::CMD_LONGER:  d3_nxt.cmp = sa2_r > sb2_r;
      vau_pkg::CMD_SHORTER: d3_nxt.cmp = sa2_r < sb2_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r  <= cmd1_nxt;
      r1_r    <= r1_nxt;
      sat1_r  <= sat1_nxt;
      eq1_r   <= eq1_nxt;
      prod1_r <= prod1_nxt;
      sqa1_r  <= sqa1_nxt;
      sqb1_r  <= sqb1_nxt;
      cmd2_r  <= cmd1_r;
      r2_r    <= r1_r;
      sat2_r  <= sat1_r;
      eq2_r   <= eq1_r;
      pos2_r  <= pos2_nxt;
      neg2_r  <= neg2_nxt;
      sa2_r   <= sa2_nxt;
      sb2_r   <= sb2_nxt;
      d3_r    <= d3_nxt;
    end
  end

  assign out_v = v3_r;
  assign out_d = d3_r;

endmodule

// ===== design/vau_len_pipe.sv =====
// Length pipeline: square roots of both squared lengths, one root bit per stage,
// then the product of the two lengths. SQ_STEPS + 1 stages. Uses vau_pkg.
`timescale 1ns / 1ps

module vau_len_pipe (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_v,
  input  vau_pkg::pl_t in_d,
  output logic         out_v,
  output vau_pkg::pl_t out_d
);

  localparam int N = vau_pkg::SQ_STEPS;

  logic [N-1:0] v_r;
  vau_pkg::pl_t st_r   [N];
  vau_pkg::pl_t st_nxt [N];
  logic         vd_r;
  vau_pkg::pl_t dd_r, dd_nxt;

  always_comb begin
    vau_pkg::pl_t cur;
    for (int k = 0; k < N; k++) begin
      cur = (k == 0) ? in_d : st_r[(k == 0) ? 0 : k-1];
      cur.sqa   = vau_pkg::sqrt_step(cur.sqa);
      cur.sqb   = vau_pkg::sqrt_step(cur.sqb);
      st_nxt[k] = cur;
    end
  end

  always_comb begin
    dd_nxt     = st_r[N-1];
    dd_nxt.den = st_r[N-1].sqa.root * st_r[N-1].sqb.root;
    if (st_r[N-1].cmd == vau_pkg::CMD_LEN) begin
      dd_nxt.scalar = vau_pkg::WIDE_W'(st_r[N-1].sqa.root);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      vd_r <= 1'b0;
    end else if (en) begin
      v_r  <= {v_r[N-2:0], in_v};
      vd_r <= v_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
      dd_r <= dd_nxt;
    end
  end

  assign out_v = vd_r;
  assign out_d = dd_r;

endmodule

// ===== design/vau_div_pipe.sv =====
// Cosine divider: |dot| / (lenA*lenB) as a Q30 quotient, one restoring step per stage,
// clamped to 1.0 when the dividend reaches the divisor. DIV_STEPS stages. Uses vau_pkg.
`timescale 1ns / 1ps

module vau_div_pipe (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_v,
  input  vau_pkg::pl_t in_d,
  output logic         out_v,
  output vau_pkg::pl_t out_d
);

  localparam int N  = vau_pkg::DIV_STEPS;
  localparam int WW = vau_pkg::WIDE_W;

  logic [N-1:0] v_r;
  vau_pkg::pl_t st_r   [N];
  vau_pkg::pl_t st_nxt [N];

  always_comb begin
    vau_pkg::pl_t cur;
    logic [WW:0]  r2;
    logic [WW:0]  dd;
    for (int k = 0; k < N; k++) begin
      cur = (k == 0) ? in_d : st_r[(k == 0) ? 0 : k-1];
      if (k == 0) begin
        cur.clamp = in_d.mag >= in_d.den;
        cur.x     = '0;
      end
      // unless clamped, the partial remainder stays below the divisor, so one extra bit covers the shift
      r2 = {cur.mag, 1'b0};
      dd = {1'b0, cur.den};
      if (r2 >= dd) begin
        cur.mag = WW'(r2 - dd);
        cur.x   = {cur.x[29:0], 1'b1};
      end else begin
        cur.mag = r2[WW-1:0];
        cur.x   = {cur.x[29:0], 1'b0};
      end
      if (k == N-1 && cur.clamp) cur.x = vau_pkg::Q30_ONE;
      st_nxt[k] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) st_r <= st_nxt;
  end

  assign out_v = v_r[N-1];
  assign out_d = st_r[N-1];

endmodule

// ===== design/vau_acos_pipe.sv =====
// Arccosine back end: sqrt(1-x) one bit per stage with the Horner polynomial in the
// first stages, final product, quadrant fix and rounding. SQ_STEPS + 2 stages. Uses vau_pkg.
`timescale 1ns / 1ps

module vau_acos_pipe (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_v,
  input  vau_pkg::pl_t in_d,
  output logic         out_v,
  output vau_pkg::pl_t out_d
);

  localparam int N  = vau_pkg::SQ_STEPS;
  localparam int WW = vau_pkg::WIDE_W;
  localparam int CW = vau_pkg::COORD_W;

  logic [N-1:0] v_r;
  vau_pkg::pl_t st_r   [N];
  vau_pkg::pl_t st_nxt [N];
  logic         vm_r, vo_r;
  vau_pkg::pl_t dm_r, dm_nxt;
  vau_pkg::pl_t do_r, do_nxt;

  always_comb begin
    vau_pkg::pl_t        cur;
    logic signed [64:0]  hp;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        cur          = in_d;
        cur.sqa.rad  = {{(WW-31){1'b0}}, 31'(vau_pkg::Q30_ONE - in_d.x)} << 30;
        cur.sqa.rem  = '0;
        cur.sqa.root = '0;
        cur.p        = vau_pkg::ACOS_COEF[7];
      end else begin
        cur = st_r[k-1];
      end
      cur.sqa = vau_pkg::sqrt_step(cur.sqa);
      if (k < vau_pkg::POLY_STEPS) begin
        hp    = cur.p * $signed({1'b0, cur.x});
        cur.p = $signed(hp[62:30]) + vau_pkg::ACOS_COEF[vau_pkg::POLY_STEPS-1-k];
      end
      st_nxt[k] = cur;
    end
  end

  always_comb begin
    logic signed [65:0] m;
    m          = $signed({1'b0, st_r[N-1].sqa.root}) * st_r[N-1].p;
    dm_nxt     = st_r[N-1];
    dm_nxt.mag = WW'(m >>> 30);
  end

  always_comb begin
    logic signed [WW-1:0] ang;
    logic [WW-1:0]        rnd;
    ang = dm_r.neg ? vau_pkg::PI_Q30 - $signed(dm_r.mag) : $signed(dm_r.mag);
    if (ang[WW-1]) ang = '0;
    rnd    = (WW'(ang) + (WW'(1) << (vau_pkg::ANG_SHIFT - 1))) >> vau_pkg::ANG_SHIFT;
    do_nxt = dm_r;
    if (dm_r.cmd == vau_pkg::CMD_ANGLE && !dm_r.zero) do_nxt.scalar = rnd;
    if (CW == 0) do_nxt.scalar = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      vm_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v_r  <= {v_r[N-2:0], in_v};
      vm_r <= v_r[N-1];
      vo_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
      dm_r <= dm_nxt;
      do_r <= do_nxt;
    end
  end

  assign out_v = vo_r;
  assign out_d = do_r;

endmodule

// ===== design/vector3_arithmetic_unit.sv =====
// Vector3 arithmetic unit: add, sub, dot, length, angle, equal, longer, shorter.
// Sections in order: front, length roots, divide, arccosine; one transaction per cycle;
// the whole pipeline advances together and holds while the output register is full
// and not taken. Synchronous active-low reset clears the valid bits only. Depends
// on vau_pkg and the four pipeline sections.
`timescale 1ns / 1ps

module vector3_arithmetic_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          in_cmd,
  input  logic signed [vau_pkg::COORD_W-1:0]  in_a_x,
  input  logic signed [vau_pkg::COORD_W-1:0]  in_a_y,
  input  logic signed [vau_pkg::COORD_W-1:0]  in_a_z,
  input  logic signed [vau_pkg::COORD_W-1:0]  in_b_x,
  input  logic signed [vau_pkg::COORD_W-1:0]  in_b_y,
  input  logic signed [vau_pkg::COORD_W-1:0]  in_b_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [vau_pkg::COORD_W-1:0]  out_res_x,
  output logic signed [vau_pkg::COORD_W-1:0]  out_res_y,
  output logic signed [vau_pkg::COORD_W-1:0]  out_res_z,
  output logic signed [vau_pkg::WIDE_W-1:0]   out_scalar,
  output logic                                out_compare_true,
  output logic [1:0]                          out_error_code
);

  logic         en;
  logic         f_v, l_v, d_v, a_v;
  vau_pkg::pl_t f_d, l_d, d_d, a_d;

  assign en       = !a_v || out_ready;
  assign in_ready = en;

  vau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_a_x   (in_a_x),
    .in_a_y   (in_a_y),
    .in_a_z   (in_a_z),
    .in_b_x   (in_b_x),
    .in_b_y   (in_b_y),
    .in_b_z   (in_b_z),
    .out_v    (f_v),
    .out_d    (f_d)
  );

  vau_len_pipe u_len (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (f_v),
    .in_d  (f_d),
    .out_v (l_v),
    .out_d (l_d)
  );

  vau_div_pipe u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (l_v),
    .in_d  (l_d),
    .out_v (d_v),
    .out_d (d_d)
  );

  vau_acos_pipe u_acos (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (d_v),
    .in_d  (d_d),
    .out_v (a_v),
    .out_d (a_d)
  );

  assign out_valid        = a_v;
  assign out_res_x        = a_d.rx;
  assign out_res_y        = a_d.ry;
  assign out_res_z        = a_d.rz;
  assign out_scalar       = a_d.scalar;
  assign out_compare_true = a_d.cmp;
  assign out_error_code   = a_d.err;

  a_err_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error_code != 2'd3)
    else $error("illegal error code");

  a_zero_len_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code == vau_pkg::ERR_ZERO |->
      out_scalar == '0 && !out_compare_true && out_res_x == '0)
    else $error("zero-length angle result not clean");

  a_compare_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_compare_true |->
      out_scalar == '0 && out_error_code == vau_pkg::ERR_OK &&
      out_res_x == '0 && out_res_y == '0 && out_res_z == '0)
    else $error("compare result mixed with other outputs");

endmodule
